FILE: src/wlp_pkg.sv
package wlp_pkg;

    localparam int TICK_W      = 48;   // one tick counter field
    localparam int ACC_W       = 64;   // busy / total accumulator width
    localparam int PCT_W       = 7;    // load_percent field
    localparam int WIN_CFG_W   = 5;    // window_length register
    localparam int S_TDATA_W   = 4 * TICK_W;
    localparam int M_TDATA_W   = 8;
    localparam int PROD_W      = ACC_W + PCT_W;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [WIN_CFG_W-1:0] WIN_RESET = 5'd16;
    localparam logic [PCT_W-1:0]     PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0]     PCT_NONE  = 7'd0;

    // Control from sequencer to serial datapath
    typedef struct packed {
        logic load_ticks;
        logic load_hist;
    } ser_ctl_t;

    // Status from serial datapath
    typedef struct packed {
        logic done;
        logic old_total_zero;
        logic dtotal_zero;
        logic dbusy_ge;
    } ser_stat_t;

endpackage

FILE: src/wlp_ram.sv
module wlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/wlp_serial.sv
// LSB-first bit-serial datapath: busy/total sums, deltas and delta compare.
module wlp_serial (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wlp_pkg::ser_ctl_t                   ctl,
    input  logic [wlp_pkg::TICK_W-1:0]          user_ticks,
    input  logic [wlp_pkg::TICK_W-1:0]          nice_ticks,
    input  logic [wlp_pkg::TICK_W-1:0]          system_ticks,
    input  logic [wlp_pkg::TICK_W-1:0]          idle_ticks,
    input  logic [wlp_pkg::ACC_W-1:0]           old_busy,
    input  logic [wlp_pkg::ACC_W-1:0]           old_total,
    output logic [wlp_pkg::ACC_W-1:0]           busy,
    output logic [wlp_pkg::ACC_W-1:0]           total,
    output logic [wlp_pkg::ACC_W-1:0]           dbusy,
    output logic [wlp_pkg::ACC_W-1:0]           dtotal,
    output wlp_pkg::ser_stat_t                  stat
);

    localparam int CNT_W = $clog2(wlp_pkg::ACC_W);

    logic [wlp_pkg::TICK_W-1:0] u_reg, n_reg, s_reg, i_reg;
    logic [wlp_pkg::ACC_W-1:0]  ob_reg, ot_reg;
    logic [wlp_pkg::ACC_W-1:0]  busy_reg, total_reg, db_reg, dt_reg;
    logic [1:0]                 cb_reg;      // 3-input adder carry
    logic                       ct_reg;      // total adder carry
    logic                       bb_reg, bt_reg, bc_reg;  // borrows
    logic                       ot_nz_reg, dt_nz_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       run_reg, done_reg;

    logic [2:0] sum3;
    logic [1:0] sum2, dif_b, dif_t, dif_c;
    logic       busy_bit, tot_bit, db_bit, dt_bit;

    always_comb begin
        sum3     = 3'(u_reg[0]) + 3'(n_reg[0]) + 3'(s_reg[0]) + 3'(cb_reg);
        busy_bit = sum3[0];
        sum2     = 2'(busy_bit) + 2'(i_reg[0]) + 2'(ct_reg);
        tot_bit  = sum2[0];
        dif_b    = 2'(busy_bit) - 2'(ob_reg[0]) - 2'(bb_reg);
        db_bit   = dif_b[0];
        dif_t    = 2'(tot_bit) - 2'(ot_reg[0]) - 2'(bt_reg);
        dt_bit   = dif_t[0];
        dif_c    = 2'(db_bit) - 2'(dt_bit) - 2'(bc_reg);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && !ctl.load_hist
                        && (cnt_reg == CNT_W'(wlp_pkg::ACC_W - 1));
            if (ctl.load_hist) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(wlp_pkg::ACC_W - 1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // shift registers and serial carries
    always_ff @(posedge aclk) begin
        if (ctl.load_ticks) begin
            u_reg <= user_ticks;
            n_reg <= nice_ticks;
            s_reg <= system_ticks;
            i_reg <= idle_ticks;
        end else if (run_reg) begin
            u_reg <= u_reg >> 1;
            n_reg <= n_reg >> 1;
            s_reg <= s_reg >> 1;
            i_reg <= i_reg >> 1;
        end
        if (ctl.load_hist) begin
            ob_reg    <= old_busy;
            ot_reg    <= old_total;
            cb_reg    <= '0;
            ct_reg    <= 1'b0;
            bb_reg    <= 1'b0;
            bt_reg    <= 1'b0;
            bc_reg    <= 1'b0;
            ot_nz_reg <= 1'b0;
            dt_nz_reg <= 1'b0;
        end else if (run_reg) begin
            ob_reg    <= ob_reg >> 1;
            ot_reg    <= ot_reg >> 1;
            cb_reg    <= sum3[2:1];
            ct_reg    <= sum2[1];
            bb_reg    <= dif_b[1];
            bt_reg    <= dif_t[1];
            bc_reg    <= dif_c[1];
            ot_nz_reg <= ot_nz_reg | ot_reg[0];
            dt_nz_reg <= dt_nz_reg | dt_bit;
            busy_reg  <= {busy_bit, busy_reg[wlp_pkg::ACC_W-1:1]};
            total_reg <= {tot_bit, total_reg[wlp_pkg::ACC_W-1:1]};
            db_reg    <= {db_bit, db_reg[wlp_pkg::ACC_W-1:1]};
            dt_reg    <= {dt_bit, dt_reg[wlp_pkg::ACC_W-1:1]};
        end
    end

    assign busy   = busy_reg;
    assign total  = total_reg;
    assign dbusy  = db_reg;
    assign dtotal = dt_reg;

    always_comb begin
        stat.done           = done_reg;
        stat.old_total_zero = !ot_nz_reg;
        stat.dtotal_zero    = !dt_nz_reg;
        stat.dbusy_ge       = !bc_reg;   // no borrow out of dbusy - dtotal
    end

endmodule

FILE: src/wlp_pct_div.sv
// floor(100 * num / den) for num < den: one multiply, then 7 restoring steps.
module wlp_pct_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wlp_pkg::ACC_W-1:0]    num,
    input  logic [wlp_pkg::ACC_W-1:0]    den,
    output logic [wlp_pkg::PCT_W-1:0]    quo,
    output logic                         done
);

    localparam int STEP_W = $clog2(wlp_pkg::PCT_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_STEP
    } div_state_t;

    div_state_t                    state_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          done_reg;
    logic [wlp_pkg::ACC_W-1:0]     num_reg;
    logic [wlp_pkg::PROD_W-1:0]    x_reg, dsh_reg;
    logic [wlp_pkg::PCT_W-1:0]     quo_reg;

    logic                          fits;
    logic [wlp_pkg::PROD_W-1:0]    x_sub;

    always_comb begin
        fits  = (x_reg >= dsh_reg);
        x_sub = x_reg - dsh_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == D_STEP)
                        && (step_reg == STEP_W'(wlp_pkg::PCT_W - 1));
            case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        state_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    step_reg  <= '0;
                    state_reg <= D_STEP;
                end
                D_STEP: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(wlp_pkg::PCT_W - 1)) begin
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start && state_reg == D_IDLE) begin
            num_reg <= num;
            dsh_reg <= wlp_pkg::PROD_W'(den) << (wlp_pkg::PCT_W - 1);
        end
        if (state_reg == D_MUL) begin
            x_reg <= num_reg * wlp_pkg::PROD_W'(wlp_pkg::PCT_FULL);
        end
        if (state_reg == D_STEP) begin
            if (fits) begin
                x_reg <= x_sub;
            end
            quo_reg <= {quo_reg[wlp_pkg::PCT_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

FILE: src/windowed_load_percent_core.sv
// An accepted s_ word passes a history read, the bit-serial sums and deltas,
//   the divider and the hold state before it reaches the output register.
// A new word is taken only once the last result has left the hold state.
// A finished result waits in the output register while the next word is taken.
// Reset (aresetn low, synchronous): history reads as zero, index 0, window 16.
module windowed_load_percent_core #(
    parameter int MAX_WINDOW = wlp_pkg::MAX_WINDOW_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config: window_length
    input  logic                             cfg_we,
    input  logic [wlp_pkg::WIN_CFG_W-1:0]    cfg_wdata,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [47:0] user_ticks, [95:48] nice_ticks, [143:96] system_ticks,
    // [191:144] idle_ticks
    input  logic [wlp_pkg::S_TDATA_W-1:0]    s_tdata,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] load_percent, [7] zero
    output logic [wlp_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int WIN_W = (CNT_W > wlp_pkg::WIN_CFG_W) ? CNT_W : wlp_pkg::WIN_CFG_W;
    localparam int TW    = wlp_pkg::TICK_W;
    localparam int AW    = wlp_pkg::ACC_W;

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for a word
        ST_READ,    // history entry arrives from the RAM
        ST_SERIAL,  // bit-serial sums and deltas
        ST_DIV,     // percentage divide
        ST_HOLD     // result waits for the output register
    } state_t;

    state_t                         state_reg;
    logic [wlp_pkg::WIN_CFG_W-1:0]  window_length_reg;
    logic [IDX_W-1:0]               ring_idx_reg, ring_idx_next;
    logic [IDX_W-1:0]               cur_idx_reg;
    logic [MAX_WINDOW-1:0]          valid_reg;     // history entry written since reset
    logic                           out_valid_reg;
    logic [wlp_pkg::PCT_W-1:0]      out_pct_reg, pct_next;

    logic                           accept;
    logic                           out_free;
    logic [WIN_W-1:0]               win_ext, win_eff, idx_inc;

    wlp_pkg::ser_ctl_t              ser_ctl;
    wlp_pkg::ser_stat_t             ser_stat;
    logic [AW-1:0]                  old_busy, old_total;
    logic [AW-1:0]                  busy, total, dbusy, dtotal;
    logic [2*AW-1:0]                ram_q;
    logic                           div_start, div_done;
    logic [wlp_pkg::PCT_W-1:0]      div_quo;
    logic                           hist_we;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Effective window: zero acts as 1, anything past MAX_WINDOW is clamped.
    always_comb begin
        win_ext = WIN_W'(window_length_reg);
        if (win_ext == '0) begin
            win_eff = WIN_W'(1);
        end else if (win_ext > WIN_W'(MAX_WINDOW)) begin
            win_eff = WIN_W'(MAX_WINDOW);
        end else begin
            win_eff = win_ext;
        end
        idx_inc = WIN_W'(ring_idx_reg) + WIN_W'(1);
        // a shortened window still uses the current slot, then wraps
        if (idx_inc >= win_eff) begin
            ring_idx_next = '0;
        end else begin
            ring_idx_next = idx_inc[IDX_W-1:0];
        end
    end

    // Unwritten history entries read as zero.
    always_comb begin
        if (valid_reg[cur_idx_reg]) begin
            old_busy  = ram_q[AW-1:0];
            old_total = ram_q[2*AW-1:AW];
        end else begin
            old_busy  = '0;
            old_total = '0;
        end
    end

    always_comb begin
        ser_ctl.load_ticks = accept;
        ser_ctl.load_hist  = (state_reg == ST_READ);
        hist_we            = (state_reg == ST_SERIAL) && ser_stat.done;
        div_start          = hist_we;
    end

    // Special cases first: empty history, flat total, busy at or above total.
    always_comb begin
        if (ser_stat.old_total_zero) begin
            pct_next = wlp_pkg::PCT_NONE;
        end else if (ser_stat.dtotal_zero || ser_stat.dbusy_ge) begin
            pct_next = wlp_pkg::PCT_FULL;
        end else begin
            pct_next = div_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            window_length_reg <= wlp_pkg::WIN_RESET;
            ring_idx_reg      <= '0;
            valid_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_length_reg <= cfg_wdata;
            end
            // output register: load from hold, else drain on m_tready
            if (state_reg == ST_HOLD && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cur_idx_reg  <= ring_idx_reg;
                        ring_idx_reg <= ring_idx_next;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_SERIAL;
                end
                ST_SERIAL: begin
                    if (ser_stat.done) begin
                        valid_reg[cur_idx_reg] <= 1'b1;
                        state_reg              <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        out_pct_reg <= pct_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = wlp_pkg::M_TDATA_W'(out_pct_reg);

    // history ring: {total, busy} per entry
    wlp_ram #(
        .WIDTH (2 * AW),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (cur_idx_reg),
        .wdata ({total, busy}),
        .re    (accept),
        .raddr (ring_idx_reg),
        .rdata (ram_q)
    );

    wlp_serial u_serial (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ser_ctl),
        .user_ticks   (s_tdata[TW-1:0]),
        .nice_ticks   (s_tdata[2*TW-1:TW]),
        .system_ticks (s_tdata[3*TW-1:2*TW]),
        .idle_ticks   (s_tdata[4*TW-1:3*TW]),
        .old_busy     (old_busy),
        .old_total    (old_total),
        .busy         (busy),
        .total        (total),
        .dbusy        (dbusy),
        .dtotal       (dtotal),
        .stat         (ser_stat)
    );

    wlp_pct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (dbusy),
        .den     (dtotal),
        .quo     (div_quo),
        .done    (div_done)
    );

endmodule

FILE: bench/wlp_load_checker.sv
`timescale 1ns / 1ps

module wlp_load_checker
    import wlp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [WIN_CFG_W-1:0]   cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    output int                     fail_count,
    output int                     pending
);

    localparam int REPORT_MAX = 10;

    logic [ACC_W-1:0]     busy_hist  [MAX_WINDOW_DEF];
    logic [ACC_W-1:0]     total_hist [MAX_WINDOW_DEF];
    int unsigned          ring_idx;
    logic [WIN_CFG_W-1:0] window_len;
    logic [PCT_W-1:0]     expected_load_q [$];
    int                   errs = 0;

    // Fold one snapshot into the history ring and return the load it yields.
    function automatic logic [PCT_W-1:0] advance_window(input logic [S_TDATA_W-1:0] w);
        logic [ACC_W-1:0]   busy, total, old_busy, old_total, d_busy, d_total;
        logic [2*ACC_W-1:0] num, den;
        int unsigned        eff_win, idx;
        busy  = ACC_W'(w[0 +: TICK_W]) + ACC_W'(w[TICK_W +: TICK_W])
              + ACC_W'(w[2*TICK_W +: TICK_W]);
        total = busy + ACC_W'(w[3*TICK_W +: TICK_W]);
        eff_win = (window_len == 0) ? 1 : int'(window_len);
        if (eff_win > MAX_WINDOW_DEF)
            eff_win = MAX_WINDOW_DEF;
        idx = (ring_idx >= MAX_WINDOW_DEF) ? 0 : ring_idx;
        old_busy        = busy_hist[idx];
        old_total       = total_hist[idx];
        busy_hist[idx]  = busy;
        total_hist[idx] = total;
        ring_idx = (idx + 1 >= eff_win) ? 0 : idx + 1;
        d_busy  = busy - old_busy;
        d_total = total - old_total;
        if (old_total == 0)
            return PCT_NONE;
        if (d_total == 0 || d_busy >= d_total)
            return PCT_FULL;
        num = d_busy;
        num = num * PCT_FULL;
        den = d_total;
        num = num / den;
        return num[PCT_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [PCT_W-1:0] want;
        if (!aresetn) begin
            foreach (busy_hist[i]) begin
                busy_hist[i]  = '0;
                total_hist[i] = '0;
            end
            ring_idx   = 0;
            window_len = WIN_RESET;
            expected_load_q.delete();
        end else begin
            if (cfg_we)
                window_len = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_load_q.push_back(advance_window(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_load_q.size() == 0) begin
                    errs++;
                    if (errs <= REPORT_MAX)
                        $display("[%0t] load word 0x%02h with none expected", $time, m_tdata);
                end else begin
                    want = expected_load_q.pop_front();
                    if (m_tdata[PCT_W-1:0] !== want || m_tdata[M_TDATA_W-1:PCT_W] !== '0) begin
                        errs++;
                        if (errs <= REPORT_MAX)
                            $display("[%0t] load_percent expected %0d, got %0d (word 0x%02h)",
                                     $time, want, m_tdata[PCT_W-1:0], m_tdata);
                    end
                end
            end
        end
        fail_count <= errs;
        pending    <= expected_load_q.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import wlp_pkg::*;
;

    // run shape
    localparam int ITEMS          = 1800;   // snapshot words in total
    localparam int HOLD_CYCLES    = 600;    // long m_tready hold-off
    localparam int SETTLE_CYCLES  = 4;      // quiet cycles before a cfg write
    localparam int TAIL_CYCLES    = 120;    // longer than one item's latency
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
    localparam int N_PLAN         = 12;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE, RX_BEAT} rx_mode_t;

    // DUT signals; the inputs are known from time zero
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [WIN_CFG_W-1:0]   cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int fail_count;
    int pending;

    // running tick counters for well-formed snapshot streams
    logic [TICK_W-1:0] user_cnt = '0;
    logic [TICK_W-1:0] nice_cnt = '0;
    logic [TICK_W-1:0] sys_cnt  = '0;
    logic [TICK_W-1:0] idle_cnt = '0;
    int freeze_left = 0;
    int burst_left  = 0;
    int words_sent  = 0;
    int hold_req    = 0;    // bumped by stimulus, consumed by the receiver
    int quiet_cycles = 0;

    // window per random phase: reset value, both legal extremes, zero and
    // out-of-range codes, and a few in between
    int unsigned win_plan [N_PLAN] = '{16, 1, 2, 31, 5, 0, 8, 15, 17, 3, 16, 1};

    always #4 aclk = ~aclk;

    windowed_load_percent_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    wlp_load_checker u_load_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // tdata layout: user lowest, then nice, system, idle
    function automatic logic [S_TDATA_W-1:0] pack_snapshot(
        input logic [TICK_W-1:0] u, input logic [TICK_W-1:0] n,
        input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] i);
        return {i, s, n, u};
    endfunction

    // random value confined to the low nbits (0 gives zero)
    function automatic logic [TICK_W-1:0] rand_below_bits(input int nbits);
        logic [TICK_W-1:0] r;
        r = TICK_W'({$urandom(), $urandom()});
        return r >> (TICK_W - nbits);
    endfunction

    // counter increment; one in ten stays flat so busy-only / idle-only
    // windows show up
    function automatic logic [TICK_W-1:0] grow(input int nbits);
        return ($urandom_range(0, 9) == 0) ? '0 : rand_below_bits(nbits);
    endfunction

    // Mostly monotone counter snapshots, with frozen runs (total unchanged),
    // noise, all-zero words, 48-bit wraps and counter restarts mixed in.
    function automatic logic [S_TDATA_W-1:0] next_snapshot();
        int dice;
        int bits;
        if (freeze_left > 0) begin
            freeze_left--;
            return pack_snapshot(user_cnt, nice_cnt, sys_cnt, idle_cnt);
        end
        dice = $urandom_range(0, 99);
        if (dice < 68) begin
            bits = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
            user_cnt = user_cnt + grow(bits);
            nice_cnt = nice_cnt + grow(bits);
            sys_cnt  = sys_cnt + grow(bits);
            idle_cnt = idle_cnt + grow(bits);
        end else if (dice < 76) begin
            freeze_left = $urandom_range(1, 20);
        end else if (dice < 88) begin
            return pack_snapshot(rand_below_bits(TICK_W), rand_below_bits(TICK_W),
                                 rand_below_bits(TICK_W), rand_below_bits(TICK_W));
        end else if (dice < 93) begin
            return '0;
        end else if (dice < 97) begin
            // huge jumps, counters roll over 48 bits
            user_cnt = user_cnt + rand_below_bits($urandom_range(44, TICK_W));
            nice_cnt = nice_cnt + rand_below_bits($urandom_range(44, TICK_W));
            sys_cnt  = sys_cnt + rand_below_bits($urandom_range(44, TICK_W));
            idle_cnt = idle_cnt + rand_below_bits($urandom_range(44, TICK_W));
        end else begin
            // counters restart low, deltas go negative mod 2^64
            user_cnt = rand_below_bits(8);
            nice_cnt = rand_below_bits(8);
            sys_cnt  = rand_below_bits(8);
            idle_cnt = rand_below_bits(8);
        end
        return pack_snapshot(user_cnt, nice_cnt, sys_cnt, idle_cnt);
    endfunction

    // Offer one word; bursts of 1..8 words separated by random gaps.
    task automatic push_snapshot(input logic [S_TDATA_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 100);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Stop offering and wait until every expected load word has come back.
    // pending is registered, hence the first wait.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // window_length is only written with the pipe empty
    task automatic write_window(input logic [WIN_CFG_W-1:0] v);
        drain_results();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: m_tready pattern changes at the end of each random span; a hold-off
    // request from stimulus forces it low for HOLD_CYCLES so the core backs up
    // into s_tready.
    initial begin : rx_pattern
        rx_mode_t mode;
        int span_left;
        int hold_left;
        int hold_seen;
        span_left = 0;
        hold_left = 0;
        hold_seen = 0;
        mode      = RX_OPEN;
        forever begin
            if (span_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                span_left = $urandom_range(20, 300);
            end
            span_left--;
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                    RX_TRICKLE: m_tready <= ($urandom_range(0, 7) == 0);
                    default:    m_tready <= ((span_left % 16) < 8);
                endcase
            end
            @(posedge aclk);
        end
    end

    // Watchdog: any handshake counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** windowed_load_percent_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        int phase_len;
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed ---
        // window 16 from reset: history empty, every load reads 0;
        // also both field extremes
        push_snapshot('0);
        push_snapshot(pack_snapshot(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX));
        push_snapshot(pack_snapshot(48'd1, 48'd2, 48'd3, 48'd4));

        // shrink to 1 with ring index at 3: slot 3 still used, then wraps
        write_window(5'd1);
        push_snapshot(pack_snapshot(48'd10, 48'd5, 48'd5, 48'd80));     // empty slot
        push_snapshot(pack_snapshot(48'd10, 48'd5, 48'd5, 48'd80));     // old total zero
        push_snapshot(pack_snapshot(48'd10, 48'd5, 48'd5, 48'd80));     // total unchanged
        push_snapshot(pack_snapshot(48'd20, 48'd5, 48'd5, 48'd120));    // 10/50
        push_snapshot(pack_snapshot(48'd20, 48'd5, 48'd5, 48'd1120));   // idle only
        push_snapshot(pack_snapshot(48'd1020, 48'd5, 48'd5, 48'd1120)); // busy == total
        push_snapshot(pack_snapshot(48'd1021, 48'd5, 48'd5, 48'd1122)); // 1/3, floored
        push_snapshot(pack_snapshot(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX));
        push_snapshot(pack_snapshot(TICK_MAX, TICK_MAX, TICK_MAX, '0));
        push_snapshot(pack_snapshot('0, '0, '0, 48'd1));                // busy delta wraps
        push_snapshot('0);                                              // stores total 0
        push_snapshot(pack_snapshot(48'd5, '0, '0, 48'd5));             // old total zero
        push_snapshot(pack_snapshot(TICK_MAX, '0, '0, TICK_MAX));

        // zero window acts as 1
        write_window(5'd0);
        push_snapshot(pack_snapshot(48'd7, 48'd7, 48'd7, 48'd7));
        push_snapshot(pack_snapshot(48'd9, 48'd7, 48'd7, 48'd100));

        // out-of-range window clamps to 16
        write_window(5'd31);
        push_snapshot(pack_snapshot(48'd100, 48'd0, 48'd0, 48'd100));
        push_snapshot(pack_snapshot(48'd150, 48'd0, 48'd0, 48'd250));

        // --- random phases ---
        phase = 0;
        while (words_sent < ITEMS) begin
            write_window((phase < N_PLAN) ? WIN_CFG_W'(win_plan[phase])
                                          : WIN_CFG_W'($urandom_range(0, 31)));
            phase_len = $urandom_range(120, 180);
            for (n = 0; n < phase_len && words_sent < ITEMS; n++) begin
                // one long receiver hold-off while words keep coming
                if (phase == 4 && n == 30)
                    hold_req <= hold_req + 1;
                push_snapshot(next_snapshot());
            end
            phase++;
        end

        // --- wind down ---
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);   // stray results land in fail_count
        if (fail_count == 0 && pending == 0)
            $display("** windowed_load_percent_core: PASSED **");
        else
            $display("** windowed_load_percent_core: FAILED **");
        $finish;
    end

endmodule

FILE: windowed_load_percent_core.f
src/wlp_pkg.sv
src/wlp_ram.sv
src/wlp_serial.sv
src/wlp_pct_div.sv
src/windowed_load_percent_core.sv
bench/wlp_load_checker.sv
bench/tb_top.sv
